/* src/wpi_pkg.sv */
// Shared types and constants for the waypoint position integrator.
`timescale 1ns / 1ps
package wpi_pkg;

  // Datapath commands issued by the controller, one per cycle.
  typedef enum logic [4:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_RCP_T,
    CMD_SPLIT_T,
    CMD_PART,
    CMD_PROD,
    CMD_RCP_R,
    CMD_SET_D,
    CMD_MUL_DM,
    CMD_MOVE,
    CMD_FOLD_CHK,
    CMD_DIV_FOLD,
    CMD_FOLD_ADJ,
    CMD_AXIS_WR,
    CMD_GOAL,
    CMD_DIR_ZERO,
    CMD_MUL_AA,
    CMD_SAVE_AA,
    CMD_MUL_BB,
    CMD_SQRT,
    CMD_SET_LEN,
    CMD_DIV_UX,
    CMD_DIR_X,
    CMD_DIV_UY,
    CMD_DIR_Y,
    CMD_OUT
  } cmd_e;

  typedef enum logic [1:0] {
    IT_MUL,
    IT_DIV,
    IT_SQRT
  } iter_op_e;

  typedef enum logic [1:0] {
    FOLD_KEEP,
    FOLD_LOW,
    FOLD_DIV
  } fold_mode_e;

  typedef enum logic [1:0] {
    REG_X_MIN,
    REG_X_MAX,
    REG_Y_MIN,
    REG_Y_MAX
  } reg_idx_e;

  typedef struct packed {
    logic       reject;
    logic       int_zero;
    logic       req;
    logic       axis;
    fold_mode_e fold_mode;
    logic       norm_zero;
    logic       busy;
  } dp_status_t;

  localparam logic [6:0]  MulSteps  = 7'd32;
  localparam logic [6:0]  DivSteps  = 7'd64;
  localparam logic [6:0]  SqrtSteps = 7'd32;
  localparam logic [63:0] SqrtTop   = 64'h4000_0000_0000_0000;
  localparam logic [63:0] RoundHalf = 64'd16384;

  // ceil(2^41 / 1000): x / 1000 is (x * RecipMs) >> 41 for 32-bit x,
  // and x / 125 is (x * RecipMs) >> 38 for 31-bit x
  localparam logic [31:0] RecipMs   = 32'd2199023256;

  localparam logic signed [31:0] AreaMaxReset = 32'sd4096000;

endpackage

/* src/waypoint_position_integrator.sv */
// Top level of the waypoint position integrator.
//   channel | direction | handshake               | payload
//   in      | input     | in_valid_i / in_ready_o   | req_type, now_time, target_x/y, new_speed
//   out     | output    | out_valid_o / out_ready_i | status, pos_x, pos_y
//   cfg     | input     | cfg_we_i                  | cfg_idx_i, cfg_data_i (area bounds)
// One item at a time. A rejected destination or zero elapsed time skips the motion; a moving
// advance runs it for each axis, with a fold divide for each axis that folds; a new destination
// adds the direction normalization (skipped when it equals the position), all on the shared
// shift-add multiply, divide and root unit (32, 64 and 32 steps). The result sits in an output
// register; the next item is taken from the cycle the result appears, and a held result stalls
// only the final step. Reset is asynchronous, active low, with no clearing pass.
`timescale 1ns / 1ps
module waypoint_position_integrator import wpi_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               req_type_i,
  input  logic [31:0]        now_time_i,
  input  logic signed [31:0] target_x_i,
  input  logic signed [31:0] target_y_i,
  input  logic [23:0]        new_speed_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               status_o,
  output logic signed [31:0] pos_x_o,
  output logic signed [31:0] pos_y_o
);

  cmd_e       cmd;
  dp_status_t dp_status;

  wpi_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .dp_i        (dp_status),
    .cmd_o       (cmd)
  );

  wpi_datapath u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (dp_status),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .req_type_i   (req_type_i),
    .now_time_i   (now_time_i),
    .target_x_i   (target_x_i),
    .target_y_i   (target_y_i),
    .new_speed_i  (new_speed_i),
    .res_status_o (status_o),
    .pos_x_o      (pos_x_o),
    .pos_y_o      (pos_y_o)
  );

endmodule

/* src/wpi_iter.sv */
// Shared iterative unit: shift-add multiply, restoring divide, integer square root.
`timescale 1ns / 1ps
module wpi_iter import wpi_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  iter_op_e    op_i,
  input  logic [63:0] opa_i,
  input  logic [63:0] opb_i,
  output logic        busy_o,
  output logic [63:0] res_b_o,
  output logic [63:0] res_c_o
);

  logic        busy_q;
  logic [6:0]  cnt_q;
  iter_op_e    op_q;
  logic [63:0] ra_q, rb_q, rc_q;
  logic [63:0] ra_d, rb_d, rc_d;

  logic [63:0] div_t, sq_s;
  logic        div_ge, sq_ge;

  assign busy_o  = busy_q | start_i;
  assign res_b_o = rb_q;
  assign res_c_o = rc_q;

  always_comb begin
    div_t  = {rc_q[62:0], rb_q[63]};
    div_ge = (div_t >= ra_q);
    sq_s   = rc_q + rb_q;
    sq_ge  = (ra_q >= sq_s);
    ra_d   = ra_q;
    rb_d   = rb_q;
    rc_d   = rc_q;
    case (op_q)
      IT_MUL: begin
        if (rb_q[0]) rc_d = rc_q + ra_q;
        ra_d = {ra_q[62:0], 1'b0};
        rb_d = {1'b0, rb_q[63:1]};
      end
      IT_DIV: begin
        rc_d = div_ge ? (div_t - ra_q) : div_t;
        rb_d = {rb_q[62:0], div_ge};
      end
      IT_SQRT: begin
        // ra holds the remainder, rb the probe bit, rc the root
        if (sq_ge) begin
          ra_d = ra_q - sq_s;
          rc_d = {1'b0, rc_q[63:1]} + rb_q;
        end else begin
          rc_d = {1'b0, rc_q[63:1]};
        end
        rb_d = {2'b00, rb_q[63:2]};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      case (op_i)
        IT_MUL:  cnt_q <= MulSteps;
        IT_DIV:  cnt_q <= DivSteps;
        default: cnt_q <= SqrtSteps;
      endcase
    end else if (busy_q) begin
      cnt_q <= cnt_q - 7'd1;
      if (cnt_q == 7'd1) busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      op_q <= op_i;
      case (op_i)
        IT_MUL: begin
          ra_q <= opa_i;
          rb_q <= {32'd0, opb_i[31:0]};
          rc_q <= '0;
        end
        IT_DIV: begin
          ra_q <= opb_i;
          rb_q <= opa_i;
          rc_q <= '0;
        end
        default: begin
          ra_q <= opa_i;
          rb_q <= SqrtTop;
          rc_q <= '0;
        end
      endcase
    end else if (busy_q) begin
      ra_q <= ra_d;
      rb_q <= rb_d;
      rc_q <= rc_d;
    end
  end

`ifndef SYNTHESIS
  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q) else $error("iterative unit restarted while busy");
  a_busy_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (cnt_q != 7'd0)) else $error("busy with zero step count");
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |=> busy_q) else $error("start did not raise busy");
`endif

endmodule

/* src/wpi_datapath.sv */
// Datapath: state, area bounds, item latch, motion and normalization arithmetic.
`timescale 1ns / 1ps
module wpi_datapath import wpi_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cmd_e               cmd_i,
  output dp_status_t         status_o,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               req_type_i,
  input  logic [31:0]        now_time_i,
  input  logic signed [31:0] target_x_i,
  input  logic signed [31:0] target_y_i,
  input  logic [23:0]        new_speed_i,
  output logic               res_status_o,
  output logic signed [31:0] pos_x_o,
  output logic signed [31:0] pos_y_o
);

  logic signed [31:0] x_min_q, x_max_q, y_min_q, y_max_q;
  logic signed [31:0] cur_x_q, cur_y_q, goal_x_q, goal_y_q;
  logic signed [16:0] dir_x_q, dir_y_q;
  logic [23:0]        speed_q;
  logic [31:0]        last_q;

  logic               req_q, reject_q, izero_q, axis_q;
  logic [31:0]        now_q;
  logic signed [31:0] tx_q, ty_q;
  logic [23:0]        spd_q;

  logic [22:0]        tq_q;
  logic [9:0]         tr_q;
  logic [33:0]        y_q;
  logic [47:0]        d_q;
  logic signed [63:0] pos_q;
  fold_mode_e         mode_q;
  logic [63:0]        span_q, absv_q, r_q;
  logic               neg_q;
  logic [30:0]        a_q, b_q;
  logic               nx_q, ny_q, nzero_q;
  logic [63:0]        sq_q;
  logic [31:0]        len_q;

  logic               out_status_q;
  logic signed [31:0] out_x_q, out_y_q;

  // iterative unit hookup
  logic        it_start, it_busy;
  iter_op_e    it_op;
  logic [63:0] it_a, it_b, it_res_b, it_res_c;

  wpi_iter u_iter (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (it_start),
    .op_i    (it_op),
    .opa_i   (it_a),
    .opb_i   (it_b),
    .busy_o  (it_busy),
    .res_b_o (it_res_b),
    .res_c_o (it_res_c)
  );

  // per-axis selection
  logic signed [31:0] cur_sel, goal_sel, lo_sel, hi_sel;
  logic signed [16:0] dir_sel;
  logic signed [63:0] cur64, goal64, lo64, hi64, span64, v64;
  logic [16:0]        mag_sel;
  logic [63:0]        delta, per, r0, rr;
  logic signed [63:0] move_pos, fold_val;
  logic               dir_neg, dir_pos;
  logic               reject_in;
  logic signed [32:0] dx, dy;
  logic [31:0]        ax, ay;
  logic               shift1;
  logic [16:0]        quo;
  logic [31:0]        interval, t_rem;
  logic [46:0]        spd_tq;
  logic [33:0]        spd_tr;

  always_comb begin
    cur_sel  = axis_q ? cur_y_q  : cur_x_q;
    goal_sel = axis_q ? goal_y_q : goal_x_q;
    lo_sel   = axis_q ? y_min_q  : x_min_q;
    hi_sel   = axis_q ? y_max_q  : x_max_q;
    dir_sel  = axis_q ? dir_y_q  : dir_x_q;
    cur64    = {{32{cur_sel[31]}}, cur_sel};
    goal64   = {{32{goal_sel[31]}}, goal_sel};
    lo64     = {{32{lo_sel[31]}}, lo_sel};
    hi64     = {{32{hi_sel[31]}}, hi_sel};
    dir_neg  = dir_sel[16];
    dir_pos  = !dir_sel[16] && (dir_sel != 17'sd0);
    mag_sel  = dir_neg ? 17'(-dir_sel) : 17'(dir_sel);

    // elapsed time split as interval = 1000 * tq + tr
    interval = now_q - last_q;
    t_rem    = interval - ({9'd0, tq_q} * 32'd1000);
    spd_tq   = {23'd0, speed_q} * {24'd0, tq_q};
    spd_tr   = {10'd0, speed_q} * {24'd0, tr_q};

    delta    = (it_res_c + RoundHalf) >> 15;
    move_pos = dir_neg ? (cur64 - $signed(delta)) : (cur64 + $signed(delta));
    if ((dir_pos && move_pos > goal64) || (dir_neg && move_pos < goal64)) move_pos = goal64;

    span64   = hi64 - lo64;
    v64      = pos_q - lo64;
    per      = {span_q[62:0], 1'b0};
    r0       = it_res_c;
    rr       = (r_q > span_q) ? (per - r_q) : r_q;
    fold_val = lo64 + $signed(rr);

    reject_in = (target_x_i >= x_max_q) || (target_x_i <= x_min_q) ||
                (target_y_i >= y_max_q) || (target_y_i <= y_min_q);

    dx     = {tx_q[31], tx_q} - {cur_x_q[31], cur_x_q};
    dy     = {ty_q[31], ty_q} - {cur_y_q[31], cur_y_q};
    ax     = dx[32] ? 32'(-dx) : dx[31:0];
    ay     = dy[32] ? 32'(-dy) : dy[31:0];
    shift1 = ax[31] | ay[31];
    quo    = it_res_b[16:0];
  end

  always_comb begin
    it_start = 1'b0;
    it_op    = IT_MUL;
    it_a     = '0;
    it_b     = '0;
    case (cmd_i)
      CMD_RCP_T: begin
        it_start = 1'b1;
        it_a     = {32'd0, interval};
        it_b     = {32'd0, RecipMs};
      end
      CMD_RCP_R: begin
        // speed * tr / 1000 taken as (speed * tr / 8) / 125
        it_start = 1'b1;
        it_a     = {33'd0, y_q[33:3]};
        it_b     = {32'd0, RecipMs};
      end
      CMD_MUL_DM: begin
        it_start = 1'b1;
        it_a     = {16'd0, d_q};
        it_b     = {47'd0, mag_sel};
      end
      CMD_DIV_FOLD: begin
        it_start = 1'b1;
        it_op    = IT_DIV;
        it_a     = absv_q;
        it_b     = per;
      end
      CMD_MUL_AA: begin
        it_start = 1'b1;
        it_a     = {33'd0, a_q};
        it_b     = {33'd0, a_q};
      end
      CMD_MUL_BB: begin
        it_start = 1'b1;
        it_a     = {33'd0, b_q};
        it_b     = {33'd0, b_q};
      end
      CMD_SQRT: begin
        it_start = 1'b1;
        it_op    = IT_SQRT;
        it_a     = sq_q + it_res_c;
      end
      CMD_DIV_UX: begin
        it_start = 1'b1;
        it_op    = IT_DIV;
        it_a     = {18'd0, a_q, 15'd0} + {33'd0, len_q[31:1]};
        it_b     = {32'd0, len_q};
      end
      CMD_DIV_UY: begin
        it_start = 1'b1;
        it_op    = IT_DIV;
        it_a     = {18'd0, b_q, 15'd0} + {33'd0, len_q[31:1]};
        it_b     = {32'd0, len_q};
      end
      default: ;
    endcase
  end

  // architectural state and bounds
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_min_q  <= '0;
      x_max_q  <= AreaMaxReset;
      y_min_q  <= '0;
      y_max_q  <= AreaMaxReset;
      cur_x_q  <= '0;
      cur_y_q  <= '0;
      goal_x_q <= '0;
      goal_y_q <= '0;
      dir_x_q  <= '0;
      dir_y_q  <= '0;
      speed_q  <= '0;
      last_q   <= '0;
      axis_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (reg_idx_e'(cfg_idx_i))
          REG_X_MIN: x_min_q <= cfg_data_i;
          REG_X_MAX: x_max_q <= cfg_data_i;
          REG_Y_MIN: y_min_q <= cfg_data_i;
          REG_Y_MAX: y_max_q <= cfg_data_i;
        endcase
      end
      case (cmd_i)
        CMD_LOAD: axis_q <= 1'b0;
        CMD_AXIS_WR: begin
          unique case (mode_q)
            FOLD_LOW: begin
              if (axis_q) cur_y_q <= lo_sel; else cur_x_q <= lo_sel;
            end
            FOLD_DIV: begin
              if (axis_q) cur_y_q <= fold_val[31:0]; else cur_x_q <= fold_val[31:0];
            end
            default: begin
              if (axis_q) cur_y_q <= pos_q[31:0]; else cur_x_q <= pos_q[31:0];
            end
          endcase
          axis_q <= ~axis_q;
          last_q <= now_q;
        end
        CMD_GOAL: begin
          goal_x_q <= tx_q;
          goal_y_q <= ty_q;
          speed_q  <= spd_q;
          last_q   <= now_q;
        end
        CMD_DIR_ZERO: begin
          dir_x_q <= '0;
          dir_y_q <= '0;
        end
        CMD_DIR_X: dir_x_q <= nx_q ? -$signed(quo) : $signed(quo);
        CMD_DIR_Y: dir_y_q <= ny_q ? -$signed(quo) : $signed(quo);
        default: ;
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    case (cmd_i)
      CMD_LOAD: begin
        req_q    <= req_type_i;
        now_q    <= now_time_i;
        tx_q     <= target_x_i;
        ty_q     <= target_y_i;
        spd_q    <= new_speed_i;
        reject_q <= req_type_i & reject_in;
        izero_q  <= (now_time_i == last_q);
      end
      CMD_SPLIT_T: tq_q <= it_res_c[63:41];
      CMD_PART: begin
        d_q  <= {1'b0, spd_tq};
        tr_q <= t_rem[9:0];
      end
      CMD_PROD:  y_q <= spd_tr;
      CMD_SET_D: d_q <= d_q + {22'd0, it_res_c[63:38]};
      CMD_MOVE:  pos_q <= move_pos;
      CMD_FOLD_CHK: begin
        span_q <= span64;
        neg_q  <= v64[63];
        absv_q <= v64[63] ? 64'(-v64) : 64'(v64);
        if (lo64 > hi64) mode_q <= FOLD_KEEP;
        else if (lo64 == hi64) mode_q <= FOLD_LOW;
        else if (pos_q >= lo64 && pos_q <= hi64) mode_q <= FOLD_KEEP;
        else mode_q <= FOLD_DIV;
      end
      CMD_FOLD_ADJ: r_q <= neg_q ? ((r0 == 64'd0) ? 64'd0 : (per - r0)) : r0;
      CMD_GOAL: begin
        a_q     <= shift1 ? ax[31:1] : ax[30:0];
        b_q     <= shift1 ? ay[31:1] : ay[30:0];
        nx_q    <= dx[32];
        ny_q    <= dy[32];
        nzero_q <= (dx == 33'sd0) && (dy == 33'sd0);
      end
      CMD_SAVE_AA: sq_q <= it_res_c;
      CMD_SET_LEN: len_q <= (it_res_c == 64'd0) ? 32'd1 : it_res_c[31:0];
      CMD_OUT: begin
        out_status_q <= reject_q;
        out_x_q      <= cur_x_q;
        out_y_q      <= cur_y_q;
      end
      default: ;
    endcase
  end

  assign status_o = '{reject:    reject_q,
                      int_zero:  izero_q,
                      req:       req_q,
                      axis:      axis_q,
                      fold_mode: mode_q,
                      norm_zero: nzero_q,
                      busy:      it_busy};

  assign res_status_o = out_status_q;
  assign pos_x_o      = out_x_q;
  assign pos_y_o      = out_y_q;

endmodule

/* src/wpi_ctrl.sv */
// Controller: sequences the datapath commands for one item and owns both handshakes.
`timescale 1ns / 1ps
module wpi_ctrl import wpi_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  input  dp_status_t dp_i,
  output cmd_e       cmd_o
);

  typedef enum logic [4:0] {
    S_IDLE, S_CHECK0, S_CHECK, S_W_T, S_SPLIT, S_PART, S_PROD, S_W_R, S_AX,
    S_W_DM, S_MOVE, S_CHK0, S_CHKD, S_W_FOLD, S_ADJ, S_AXW, S_SET, S_G0, S_GD,
    S_W_AA, S_SAA, S_W_BB, S_W_SQ, S_LEN, S_W_UX, S_DX, S_W_UY,
    S_FIN, S_OUT
  } state_e;

  state_e state_q;
  cmd_e   cmd_q;
  logic   out_valid_q;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  // the item is latched at the accepting edge itself
  assign cmd_o       = (in_ready_o && in_valid_i) ? CMD_LOAD : cmd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cmd_q       <= CMD_NONE;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      cmd_q <= CMD_NONE;
      unique case (state_q)
        S_IDLE: if (in_valid_i) begin
          state_q <= S_CHECK0;
        end
        S_CHECK0: state_q <= S_CHECK;
        S_CHECK: begin
          if (dp_i.reject) state_q <= S_FIN;
          else if (dp_i.int_zero) state_q <= dp_i.req ? S_SET : S_FIN;
          else begin
            cmd_q   <= CMD_RCP_T;
            state_q <= S_W_T;
          end
        end
        S_W_T: if (!dp_i.busy) begin
          cmd_q   <= CMD_SPLIT_T;
          state_q <= S_SPLIT;
        end
        S_SPLIT: begin
          cmd_q   <= CMD_PART;
          state_q <= S_PART;
        end
        S_PART: begin
          cmd_q   <= CMD_PROD;
          state_q <= S_PROD;
        end
        S_PROD: begin
          cmd_q   <= CMD_RCP_R;
          state_q <= S_W_R;
        end
        S_W_R: if (!dp_i.busy) begin
          cmd_q   <= CMD_SET_D;
          state_q <= S_AX;
        end
        S_AX: begin
          cmd_q   <= CMD_MUL_DM;
          state_q <= S_W_DM;
        end
        S_W_DM: if (!dp_i.busy) begin
          cmd_q   <= CMD_MOVE;
          state_q <= S_MOVE;
        end
        S_MOVE: begin
          cmd_q   <= CMD_FOLD_CHK;
          state_q <= S_CHK0;
        end
        S_CHK0: state_q <= S_CHKD;
        S_CHKD: begin
          if (dp_i.fold_mode == FOLD_DIV) begin
            cmd_q   <= CMD_DIV_FOLD;
            state_q <= S_W_FOLD;
          end else begin
            cmd_q   <= CMD_AXIS_WR;
            state_q <= S_AXW;
          end
        end
        S_W_FOLD: if (!dp_i.busy) begin
          cmd_q   <= CMD_FOLD_ADJ;
          state_q <= S_ADJ;
        end
        S_ADJ: begin
          cmd_q   <= CMD_AXIS_WR;
          state_q <= S_AXW;
        end
        // the axis write runs in this cycle; axis still shows the one being written
        S_AXW: begin
          if (!dp_i.axis) begin
            cmd_q   <= CMD_MUL_DM;
            state_q <= S_W_DM;
          end else begin
            state_q <= dp_i.req ? S_SET : S_FIN;
          end
        end
        S_SET: begin
          cmd_q   <= CMD_GOAL;
          state_q <= S_G0;
        end
        S_G0: state_q <= S_GD;
        S_GD: begin
          if (dp_i.norm_zero) begin
            cmd_q   <= CMD_DIR_ZERO;
            state_q <= S_FIN;
          end else begin
            cmd_q   <= CMD_MUL_AA;
            state_q <= S_W_AA;
          end
        end
        S_W_AA: if (!dp_i.busy) begin
          cmd_q   <= CMD_SAVE_AA;
          state_q <= S_SAA;
        end
        S_SAA: begin
          cmd_q   <= CMD_MUL_BB;
          state_q <= S_W_BB;
        end
        S_W_BB: if (!dp_i.busy) begin
          cmd_q   <= CMD_SQRT;
          state_q <= S_W_SQ;
        end
        S_W_SQ: if (!dp_i.busy) begin
          cmd_q   <= CMD_SET_LEN;
          state_q <= S_LEN;
        end
        S_LEN: begin
          cmd_q   <= CMD_DIV_UX;
          state_q <= S_W_UX;
        end
        S_W_UX: if (!dp_i.busy) begin
          cmd_q   <= CMD_DIR_X;
          state_q <= S_DX;
        end
        S_DX: begin
          cmd_q   <= CMD_DIV_UY;
          state_q <= S_W_UY;
        end
        S_W_UY: if (!dp_i.busy) begin
          cmd_q   <= CMD_DIR_Y;
          state_q <= S_FIN;
        end
        // wait for the output slot to free up
        S_FIN: if (!out_valid_q || out_ready_i) begin
          cmd_q   <= CMD_OUT;
          state_q <= S_OUT;
        end
        S_OUT: begin
          out_valid_q <= 1'b1;
          state_q     <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT) |-> !out_valid_q) else $error("result overwritten before taken");
  a_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |-> (cmd_o == CMD_LOAD)) else $error("item not loaded");
  a_reject: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CHECK && dp_i.reject) |=> (state_q == S_FIN))
    else $error("rejected item touched state");
`endif

endmodule

/* tb/wpi_checker.sv */
// Checker for the waypoint position integrator: predicts each item's result and compares.
`timescale 1ns / 1ps
module wpi_checker import wpi_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic               req_type_i,
  input  logic [31:0]        now_time_i,
  input  logic signed [31:0] target_x_i,
  input  logic signed [31:0] target_y_i,
  input  logic [23:0]        new_speed_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic               status_i,
  input  logic signed [31:0] pos_x_i,
  input  logic signed [31:0] pos_y_i,
  output int                 fail_count_o,
  output int                 pending_o
);

  typedef struct packed {
    logic               status;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
  } fix_t;

  fix_t pos_queue[$];

  logic signed [31:0] x_min, x_max, y_min, y_max;
  logic signed [31:0] cur_x, cur_y, goal_x, goal_y;
  logic signed [16:0] dir_x, dir_y;
  logic [23:0]        speed;
  logic [31:0]        last_t;

  function automatic longint reflect(longint p, longint lo, longint hi);
    longint span, per, r;
    if (lo > hi) return p;
    if (lo == hi) return lo;
    if (p >= lo && p <= hi) return p;
    span = hi - lo;
    per  = 2 * span;
    r    = (p - lo) % per;
    if (r < 0) r += per;
    if (r > span) r = per - r;
    return lo + r;
  endfunction

  function automatic longint step_axis(longint p, logic signed [16:0] dir,
                                       logic signed [31:0] goal, longint unsigned d,
                                       longint lo, longint hi);
    longint unsigned mag, delta;
    longint          g;
    g     = goal;
    mag   = (dir < 0) ? longint'(-dir) : longint'(dir);
    delta = (d * mag + 64'd16384) >> 15;
    if (dir < 0) p = p - longint'(delta);
    else         p = p + longint'(delta);
    if ((dir > 0 && p > g) || (dir < 0 && p < g)) p = g;
    return reflect(p, lo, hi);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, bit_w;
    r     = 0;
    bit_w = 64'h4000_0000_0000_0000;
    while (bit_w > v) bit_w = bit_w >> 2;
    while (bit_w != 0) begin
      if (v >= r + bit_w) begin
        v = v - (r + bit_w);
        r = (r >> 1) + bit_w;
      end else begin
        r = r >> 1;
      end
      bit_w = bit_w >> 2;
    end
    return r;
  endfunction

  task automatic move_to(logic [31:0] now);
    logic [31:0]     dt;
    longint unsigned d;
    dt = now - last_t;
    if (dt == 0) return;
    d = (longint'(speed) * longint'(dt)) / 1000;
    cur_x  = 32'(step_axis(cur_x, dir_x, goal_x, d, x_min, x_max));
    cur_y  = 32'(step_axis(cur_y, dir_y, goal_y, d, y_min, y_max));
    last_t = now;
  endtask

  task automatic aim();
    longint          dx, dy;
    longint unsigned a, b, len;
    dx = longint'(goal_x) - longint'(cur_x);
    dy = longint'(goal_y) - longint'(cur_y);
    a  = (dx < 0) ? -dx : dx;
    b  = (dy < 0) ? -dy : dy;
    if (a == 0 && b == 0) begin
      dir_x = '0;
      dir_y = '0;
      return;
    end
    while (a >= 64'h8000_0000 || b >= 64'h8000_0000) begin
      a = a >> 1;
      b = b >> 1;
    end
    len = int_sqrt(a * a + b * b);
    if (len == 0) len = 1;
    a = (a * 32768 + len / 2) / len;
    b = (b * 32768 + len / 2) / len;
    dir_x = (dx < 0) ? -17'(a) : 17'(a);
    dir_y = (dy < 0) ? -17'(b) : 17'(b);
  endtask

  task automatic predict(logic req, logic [31:0] now, logic signed [31:0] tx,
                         logic signed [31:0] ty, logic [23:0] spd);
    fix_t f;
    f.status = 1'b0;
    if (!req) begin
      move_to(now);
    end else if (tx >= x_max || tx <= x_min || ty >= y_max || ty <= y_min) begin
      f.status = 1'b1;
    end else begin
      move_to(now);
      goal_x = tx;
      goal_y = ty;
      speed  = spd;
      aim();
      last_t = now;
    end
    f.pos_x = cur_x;
    f.pos_y = cur_y;
    pos_queue.push_back(f);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    fix_t f;
    if (!rst_ni) begin
      x_min = '0; x_max = AreaMaxReset; y_min = '0; y_max = AreaMaxReset;
      cur_x = '0; cur_y = '0; goal_x = '0; goal_y = '0;
      dir_x = '0; dir_y = '0; speed = '0; last_t = '0;
      pos_queue.delete();
      fail_count_o = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (pos_queue.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= 10) $display("unexpected result: status %0d pos %0d,%0d",
                                           status_i, pos_x_i, pos_y_i);
        end else begin
          f = pos_queue.pop_front();
          if (f.status !== status_i || f.pos_x !== pos_x_i || f.pos_y !== pos_y_i) begin
            fail_count_o++;
            if (fail_count_o <= 10)
              $display("mismatch: expected status %0d pos %0d,%0d got status %0d pos %0d,%0d",
                       f.status, f.pos_x, f.pos_y, status_i, pos_x_i, pos_y_i);
          end
        end
      end
      if (cfg_we_i) begin
        case (reg_idx_e'(cfg_idx_i))
          REG_X_MIN: x_min = cfg_data_i;
          REG_X_MAX: x_max = cfg_data_i;
          REG_Y_MIN: y_min = cfg_data_i;
          REG_Y_MAX: y_max = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i)
        predict(req_type_i, now_time_i, target_x_i, target_y_i, new_speed_i);
    end
    pending_o = pos_queue.size();
  end

endmodule

/* tb/tb_waypoint_position_integrator.sv */
// Testbench top: stimulus, handshake pacing and verdict for the waypoint position integrator.
`timescale 1ns / 1ps
module tb_waypoint_position_integrator;
  import wpi_pkg::*;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [1:0]         cfg_idx_i = '0;
  logic [31:0]        cfg_data_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic               req_type_i = 1'b0;
  logic [31:0]        now_time_i = '0;
  logic signed [31:0] target_x_i = '0;
  logic signed [31:0] target_y_i = '0;
  logic [23:0]        new_speed_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic               status_o;
  logic signed [31:0] pos_x_o, pos_y_o;
  int                 fail_count, pending;

  bit                 no_gaps;
  logic [31:0]        t_sent;
  logic signed [31:0] a_xmin, a_xmax, a_ymin, a_ymax;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  waypoint_position_integrator dut (.*);

  wpi_checker u_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_ready_i(in_ready_o), .req_type_i, .now_time_i,
    .target_x_i, .target_y_i, .new_speed_i,
    .out_valid_i(out_valid_o), .out_ready_i, .status_i(status_o),
    .pos_x_i(pos_x_o), .pos_y_i(pos_y_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    #200_000_000;
    $display("** waypoint_position_integrator: FAILED **");
    $finish;
  end

  // Receiver: random stall before each result.
  initial begin
    int gap;
    @(posedge rst_ni);
    forever begin
      gap = no_gaps ? 0 : $urandom_range(0, 15);
      if (gap > 0) begin
        @(negedge clk_i);
        out_ready_i = 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
      @(negedge clk_i);
      out_ready_i = 1'b1;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
    end
  end

  task automatic send(logic req, logic [31:0] now, logic signed [31:0] tx,
                      logic signed [31:0] ty, logic [23:0] spd);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req_type_i  = req;
    now_time_i  = now;
    target_x_i  = tx;
    target_y_i  = ty;
    new_speed_i = spd;
    in_valid_i  = 1'b1;
    t_sent      = now;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid_i = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  task automatic set_area(logic signed [31:0] xl, logic signed [31:0] xh,
                          logic signed [31:0] yl, logic signed [31:0] yh);
    drain();
    a_xmin = xl; a_xmax = xh; a_ymin = yl; a_ymax = yh;
    cfg_we_i = 1'b1;
    cfg_idx_i = REG_X_MIN; cfg_data_i = xl; @(negedge clk_i);
    cfg_idx_i = REG_X_MAX; cfg_data_i = xh; @(negedge clk_i);
    cfg_idx_i = REG_Y_MIN; cfg_data_i = yl; @(negedge clk_i);
    cfg_idx_i = REG_Y_MAX; cfg_data_i = yh; @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  function automatic logic signed [31:0] pick_inside(logic signed [31:0] lo,
                                                     logic signed [31:0] hi);
    longint span;
    longint unsigned r;
    span = longint'(hi) - longint'(lo);
    if (span < 2) return lo;
    r = {$urandom, $urandom};
    return 32'(longint'(lo) + 1 + longint'(r % longint'(span - 1)));
  endfunction

  function automatic logic [31:0] next_time();
    int c;
    c = $urandom_range(0, 19);
    if (c == 0) return t_sent;
    if (c == 1) return $urandom;
    if (c == 2) return t_sent + $urandom_range(0, 2_000_000);
    return t_sent + $urandom_range(1, 3000);
  endfunction

  function automatic logic [23:0] pick_speed();
    if ($urandom_range(0, 3) == 0) return 24'($urandom);
    return 24'($urandom_range(0, 200_000));
  endfunction

  task automatic random_item();
    int c;
    c = $urandom_range(0, 9);
    if (c < 4) begin
      send(1'b1, next_time(), pick_inside(a_xmin, a_xmax), pick_inside(a_ymin, a_ymax),
           pick_speed());
    end else if (c < 8) begin
      send(1'b0, next_time(), $urandom, $urandom, 24'($urandom));
    end else if (c == 8) begin
      // broken destination: each coordinate may be put on or past a bound
      send(1'b1, next_time(), ($urandom_range(0, 1) ? a_xmax : pick_inside(a_xmin, a_xmax)),
           ($urandom_range(0, 1) ? a_ymin : $urandom), pick_speed());
    end else begin
      send(1'($urandom), $urandom, $urandom, $urandom, 24'($urandom));
    end
  endtask

  task automatic directed_items();
    send(1'b0, t_sent, 32'sh7fff_ffff, 32'sh8000_0000, 24'hff_ffff);
    send(1'b1, t_sent + 1, a_xmax, pick_inside(a_ymin, a_ymax), 24'd4096);
    send(1'b1, t_sent + 1, a_xmin, pick_inside(a_ymin, a_ymax), 24'd4096);
    send(1'b1, t_sent + 1, pick_inside(a_xmin, a_xmax), a_ymax, 24'd4096);
    send(1'b1, t_sent + 1, pick_inside(a_xmin, a_xmax), a_ymin, 24'd4096);
    send(1'b1, t_sent + 10, pick_inside(a_xmin, a_xmax), pick_inside(a_ymin, a_ymax),
         24'hff_ffff);
    send(1'b0, t_sent + 1000, '0, '0, '0);
    send(1'b0, t_sent, '0, '0, '0);
    send(1'b0, t_sent + 32'hffff_ff00, '0, '0, '0);   // overshoot, long interval
    send(1'b1, t_sent + 5, a_xmin + 1, a_ymax - 1, 24'd0);
    send(1'b0, t_sent - 32'd100, '0, '0, '0);         // time wraps
    send(1'b1, t_sent + 7, a_xmax - 1, a_ymin + 1, 24'hff_ffff);
    send(1'b0, 32'hffff_ffff, '0, '0, '0);
    send(1'b0, 32'd0, '0, '0, '0);
  endtask

  initial begin
    no_gaps = 1'b0;
    t_sent  = '0;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    set_area(32'sd0, 32'sd4096000, 32'sd0, 32'sd4096000);
    directed_items();
    for (int p = 0; p < 5; p++) begin
      case (p)
        0: ;
        1: set_area(-32'sd40960, 32'sd40960, -32'sd20480, 32'sd20480);
        2: set_area(32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff);
        3: set_area(32'sd12288, 32'sd12288, -32'sd81920, 32'sd81920);
        default: set_area(-32'sd81920, 32'sd81920, 32'sd40960, -32'sd40960);
      endcase
      if (p > 0) directed_items();
      for (int i = 0; i < 360; i++) begin
        if (i % 90 == 0) no_gaps = ($urandom_range(0, 2) == 0);
        random_item();
      end
      no_gaps = 1'b0;
    end
    drain();
    repeat (200) @(negedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("** waypoint_position_integrator: PASSED **");
    end else begin
      $display("** waypoint_position_integrator: FAILED **");
    end
    $finish;
  end

endmodule
